@@ sv/scnr_pkg.sv @@
// Shared types and constants for the square crop resize address unit.
package scnr_pkg;

	localparam int OUT_HEIGHT_DEF = 112;
	localparam int OUT_WIDTH_DEF  = 112;
	localparam int DET_WIDTH_DEF  = 256;
	localparam int DET_HEIGHT_DEF = 256;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_BOX_LEFT   = 2'd0,
		REG_BOX_TOP    = 2'd1,
		REG_BOX_RIGHT  = 2'd2,
		REG_BOX_BOTTOM = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [6:0] out_row;
		logic [6:0] out_col;
	} in_word_t;

	typedef struct packed {
		logic [13:0] out_index;
		logic [15:0] src_index;
		logic        zero_fill;
	} out_word_t;

	// Per-stage load enables of the pipeline
	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
	} stage_en_t;

endpackage

@@ sv/scnr_loc.sv @@
// Nearest-neighbor source offset: round(k*side/N) with halves up, clamped to side-1.
module scnr_loc #(
	parameter int N_OUT = scnr_pkg::OUT_WIDTH_DEF
) (
	input  logic                clk,
	input  scnr_pkg::stage_en_t en,
	input  logic [6:0]          k_s1,
	input  logic [7:0]          side_s1,
	output logic [7:0]          loc_s4
);
	import scnr_pkg::*;

	localparam int NUM_W = 17;
	localparam int SH    = NUM_W;
	localparam int DIV   = 2 * N_OUT;
	localparam int DIV_W = $clog2(DIV + 1);
	localparam int RECIP = (1 << SH) / DIV;

	localparam logic [NUM_W-1:0] N_C     = NUM_W'(N_OUT);
	localparam logic [NUM_W-1:0] RECIP_C = NUM_W'(RECIP);
	localparam logic [DIV_W-1:0] DIV_C   = DIV_W'(DIV);

	logic [15:0]        prod_c;
	logic [NUM_W-1:0]   num_c;
	logic [NUM_W-1:0]   num_s2;
	logic [7:0]         side_s2;
	logic [2*NUM_W-1:0] recip_prod;
	logic [NUM_W-1:0]   q_s3;
	logic [NUM_W-1:0]   num_s3;
	logic [7:0]         side_s3;
	logic [NUM_W+DIV_W-1:0] qd_full;
	logic [NUM_W-1:0]   rem;
	logic [NUM_W-1:0]   q_fix;
	logic [7:0]         lim;

	// numerator 2*k*side + N
	assign prod_c = {k_s1, 1'b0} * side_s1;
	assign num_c  = {1'b0, prod_c} + N_C;

	always_ff @(posedge clk) begin
		if (en.adv_s2) begin
			num_s2  <= num_c;
			side_s2 <= side_s1;
		end
	end

	// estimate the quotient by reciprocal; it is exact or one low
	assign recip_prod = num_s2 * RECIP_C;

	always_ff @(posedge clk) begin
		if (en.adv_s3) begin
			q_s3    <= recip_prod[2*NUM_W-1:SH];
			num_s3  <= num_s2;
			side_s3 <= side_s2;
		end
	end

	assign qd_full = q_s3 * DIV_C;
	assign rem     = num_s3 - qd_full[NUM_W-1:0];
	assign q_fix   = (rem >= NUM_W'(DIV)) ? q_s3 + NUM_W'(1) : q_s3;
	assign lim     = side_s3 - 8'd1;

	always_ff @(posedge clk) begin
		if (en.adv_s4) begin
			if (q_fix > {{(NUM_W-8){1'b0}}, lim}) begin
				loc_s4 <= lim;
			end else begin
				loc_s4 <= q_fix[7:0];
			end
		end
	end

endmodule

@@ sv/square_crop_nearest_resize_addr_unit.sv @@
// Square crop around a detection box and nearest-neighbor resize address generator.
// An accepted word passes through registers s1 to s5; s5 is the output register.
// Throughput: one word per cycle while rsp_stall is low; each stage loads whenever it
// is empty or drains, so bubbles close up and while a result waits input fills them.
// The critical path per stage is one narrow multiply plus an add or compare.
// Reset clears the valid bits and the four box registers to zero.
module square_crop_nearest_resize_addr_unit #(
	parameter int OUT_HEIGHT = scnr_pkg::OUT_HEIGHT_DEF,
	parameter int OUT_WIDTH  = scnr_pkg::OUT_WIDTH_DEF,
	parameter int DET_WIDTH  = scnr_pkg::DET_WIDTH_DEF,
	parameter int DET_HEIGHT = scnr_pkg::DET_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scnr_pkg::PADDR_W-1:0]  paddr,
	input  logic [scnr_pkg::PDATA_W-1:0]  pwdata,
	output logic [scnr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  scnr_pkg::in_word_t            req_word,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output scnr_pkg::out_word_t           rsp_word
);
	import scnr_pkg::*;

	localparam logic [8:0] OUT_H_C = 9'(OUT_HEIGHT);
	localparam logic [9:0] DET_W_C = 10'(DET_WIDTH);
	localparam logic [9:0] DET_H_L = 10'(DET_HEIGHT);
	localparam logic [8:0] DET_H_C = 9'(DET_HEIGHT);

	logic [7:0] box_left_q;
	logic [7:0] box_top_q;
	logic [7:0] box_right_q;
	logic [7:0] box_bottom_q;
	reg_idx_t   reg_sel;

	logic [7:0] bw;
	logic [7:0] bh;
	logic [7:0] side_c;
	logic [6:0] half_c;
	logic signed [9:0] ox_c;
	logic signed [9:0] oy_c;
	logic [15:0] oidx_c;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic adv_s1, adv_s5;
	stage_en_t en;

	logic [6:0]        row_s1, col_s1;
	logic [7:0]        side_s1;
	logic signed [9:0] ox_s1, ox_s2, ox_s3, ox_s4;
	logic signed [9:0] oy_s1, oy_s2, oy_s3, oy_s4;
	logic [13:0]       oidx_s1, oidx_s2, oidx_s3, oidx_s4;
	logic              zero_s1, zero_s2, zero_s3, zero_s4;
	logic [7:0]        locx_s4, locy_s4;

	logic signed [10:0] sx;
	logic signed [10:0] sy;
	logic               outside;
	logic [17:0]        src_full;
	out_word_t          rsp_s5;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_BOX_LEFT:   box_left_q   <= pwdata[7:0];
				REG_BOX_TOP:    box_top_q    <= pwdata[7:0];
				REG_BOX_RIGHT:  box_right_q  <= pwdata[7:0];
				REG_BOX_BOTTOM: box_bottom_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BOX_LEFT:   prdata = {24'd0, box_left_q};
			REG_BOX_TOP:    prdata = {24'd0, box_top_q};
			REG_BOX_RIGHT:  prdata = {24'd0, box_right_q};
			REG_BOX_BOTTOM: prdata = {24'd0, box_bottom_q};
			default:        prdata = '0;
		endcase
	end

	// square geometry from the box; widen the shorter side about the center
	assign bw = box_right_q - box_left_q;
	assign bh = box_bottom_q - box_top_q;

	always_comb begin
		if (bw > bh) begin
			side_c = bw;
			half_c = 7'((bw - bh) >> 1);
			ox_c   = $signed({2'b00, box_left_q});
			oy_c   = $signed({2'b00, box_top_q}) - $signed({3'b000, half_c});
		end else begin
			side_c = bh;
			half_c = 7'((bh - bw) >> 1);
			ox_c   = $signed({2'b00, box_left_q}) - $signed({3'b000, half_c});
			oy_c   = $signed({2'b00, box_top_q});
		end
	end

	assign oidx_c = req_word.out_col * OUT_H_C + {9'd0, req_word.out_row};

	// stage enables: load when empty or when the next stage moves on
	assign adv_s5    = !v5_s5 || !rsp_stall;
	assign en.adv_s4 = !v4_s4 || adv_s5;
	assign en.adv_s3 = !v3_s3 || en.adv_s4;
	assign en.adv_s2 = !v2_s2 || en.adv_s3;
	assign adv_s1    = !v1_s1 || en.adv_s2;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (adv_s1)    v1_s1 <= req_valid;
			if (en.adv_s2) v2_s2 <= v1_s1;
			if (en.adv_s3) v3_s3 <= v2_s2;
			if (en.adv_s4) v4_s4 <= v3_s3;
			if (adv_s5)    v5_s5 <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			row_s1  <= req_word.out_row;
			col_s1  <= req_word.out_col;
			side_s1 <= side_c;
			ox_s1   <= ox_c;
			oy_s1   <= oy_c;
			oidx_s1 <= oidx_c[13:0];
			zero_s1 <= (side_c == 8'd0);
		end
		if (en.adv_s2) begin
			ox_s2   <= ox_s1;
			oy_s2   <= oy_s1;
			oidx_s2 <= oidx_s1;
			zero_s2 <= zero_s1;
		end
		if (en.adv_s3) begin
			ox_s3   <= ox_s2;
			oy_s3   <= oy_s2;
			oidx_s3 <= oidx_s2;
			zero_s3 <= zero_s2;
		end
		if (en.adv_s4) begin
			ox_s4   <= ox_s3;
			oy_s4   <= oy_s3;
			oidx_s4 <= oidx_s3;
			zero_s4 <= zero_s3;
		end
	end

	scnr_loc #(
		.N_OUT (OUT_WIDTH)
	) u_loc_x (
		.clk     (clk),
		.en      (en),
		.k_s1    (col_s1),
		.side_s1 (side_s1),
		.loc_s4  (locx_s4)
	);

	scnr_loc #(
		.N_OUT (OUT_HEIGHT)
	) u_loc_y (
		.clk     (clk),
		.en      (en),
		.k_s1    (row_s1),
		.side_s1 (side_s1),
		.loc_s4  (locy_s4)
	);

	// source coordinate, frame check and column-major index
	assign sx = 11'(ox_s4) + $signed({3'b000, locx_s4});
	assign sy = 11'(oy_s4) + $signed({3'b000, locy_s4});

	assign outside = zero_s4 || sx[10] || sy[10] ||
		(sx[9:0] >= DET_W_C) || (sy[9:0] >= DET_H_L);

	assign src_full = sx[8:0] * DET_H_C + {9'd0, sy[8:0]};

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			rsp_s5.out_index <= oidx_s4;
			rsp_s5.src_index <= outside ? 16'd0 : src_full[15:0];
			rsp_s5.zero_fill <= outside;
		end
	end

	assign rsp_valid = v5_s5;
	assign rsp_word  = rsp_s5;

endmodule
